/* hw/rtl/slpt_pkg.sv */
// Shared types and codes of the single-level page-table MMU.
package slpt_pkg;

  localparam logic [1:0] REQ_NEW   = 2'd0;
  localparam logic [1:0] REQ_KILL  = 2'd1;
  localparam logic [1:0] REQ_STORE = 2'd2;
  localparam logic [1:0] REQ_LOAD  = 2'd3;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_NO_TABLE_PAGE = 3'd1;
  localparam logic [2:0] ST_NO_DATA_PAGE  = 3'd2;
  localparam logic [2:0] ST_NO_TABLE      = 3'd3;
  localparam logic [2:0] ST_UNMAPPED      = 3'd4;

  // RAM address sources.
  localparam logic [2:0] A_CLR   = 3'd0;
  localparam logic [2:0] A_SCAN  = 3'd1;
  localparam logic [2:0] A_PTR   = 3'd2;
  localparam logic [2:0] A_ENT   = 3'd3;
  localparam logic [2:0] A_XENT  = 3'd4;
  localparam logic [2:0] A_KMAP  = 3'd5;
  localparam logic [2:0] A_TFREE = 3'd6;
  localparam logic [2:0] A_PHYS  = 3'd7;

  // RAM write data sources.
  localparam logic [2:0] D_ZERO = 3'd0;
  localparam logic [2:0] D_ONE  = 3'd1;
  localparam logic [2:0] D_TP   = 3'd2;
  localparam logic [2:0] D_PP   = 3'd3;
  localparam logic [2:0] D_WD   = 3'd4;
  localparam logic [2:0] D_CLR  = 3'd5;

  typedef struct packed {
    logic       capture;
    logic       we;
    logic [2:0] addr_sel;
    logic [2:0] data_sel;
    logic       clr_inc;
    logic       pg_init;
    logic       pg_inc;
    logic       vp_clr;
    logic       vp_inc;
    logic       tp_ld_pg;
    logic       tp_ld_rd;
    logic       pp_ld_pg;
    logic       pp_ld_rd;
    logic       rd_ld;
    logic       st_ld;
    logic [2:0] st_val;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       pid_ok;
    logic       rzero;
    logic       rpage_ok;
    logic       pg_end;
    logic       vp_eq_cnt;
    logic       vp_eq_pages;
    logic       clr_last;
    logic       out_free;
  } sts_t;

endpackage

/* hw/rtl/single_level_page_table_mmu.sv */
// Top level of the single-level page-table MMU.
//
// The block owns NUM_PAGES pages of 256 bytes in one single-port RAM; page 0
// holds the free-page map and the per-process table pointers. After reset the
// block clears the RAM and accepts no word meanwhile. Each request then runs
// on its own, paced by the one RAM port: a kill walks the table, and a create
// runs a first-fit scan of the free-page map for its table page and for each
// page it maps. The finished result word sits in an output register, so the
// next request is taken while it waits.
module single_level_page_table_mmu import slpt_pkg::*; #(
  parameter int NUM_PAGES = 64,
  parameter int PROC_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // proc_id, pages_requested, vaddr, write_data, zero pad
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // phys_addr, read_data, table_page, pages_mapped, zero pad
  output logic [2:0]  out_tuser   // status
);

  cmd_t        cmd;
  sts_t        sts;
  logic [2:0]  o_status;
  logic [13:0] o_phys;
  logic [7:0]  o_rd;
  logic [5:0]  o_tp;
  logic [6:0]  o_mapped;

  slpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  slpt_dp #(.NUM_PAGES(NUM_PAGES), .PROC_COUNT(PROC_COUNT)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_req_type        (in_tuser),
    .in_proc_id         (in_tdata[5:0]),
    .in_pages_requested (in_tdata[12:6]),
    .in_vaddr           (in_tdata[26:13]),
    .in_write_data      (in_tdata[34:27]),
    .out_ready          (out_tready),
    .out_valid          (out_tvalid),
    .out_status         (o_status),
    .out_phys_addr      (o_phys),
    .out_read_data      (o_rd),
    .out_table_page     (o_tp),
    .out_pages_mapped   (o_mapped)
  );

  assign out_tdata = {5'd0, o_mapped, o_tp, o_rd, o_phys};
  assign out_tuser = o_status;

endmodule

/* hw/rtl/slpt_ram.sv */
// Generic single-port RAM with registered read.
module slpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/slpt_ctrl.sv */
// Request sequencer of the page-table MMU.
module slpt_ctrl import slpt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [4:0] S_CLR       = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_DECODE    = 5'd2;
  localparam logic [4:0] S_TSCAN_RD  = 5'd3;
  localparam logic [4:0] S_TSCAN_CHK = 5'd4;
  localparam logic [4:0] S_PTR_WR    = 5'd5;
  localparam logic [4:0] S_DCHECK    = 5'd6;
  localparam logic [4:0] S_DSCAN_RD  = 5'd7;
  localparam logic [4:0] S_DSCAN_CHK = 5'd8;
  localparam logic [4:0] S_ENT_WR    = 5'd9;
  localparam logic [4:0] S_KPTR      = 5'd10;
  localparam logic [4:0] S_KRD       = 5'd11;
  localparam logic [4:0] S_KCHK      = 5'd12;
  localparam logic [4:0] S_KFREE     = 5'd13;
  localparam logic [4:0] S_KPTRCLR   = 5'd14;
  localparam logic [4:0] S_XPTR      = 5'd15;
  localparam logic [4:0] S_XENT_RD   = 5'd16;
  localparam logic [4:0] S_XENT      = 5'd17;
  localparam logic [4:0] S_XACC      = 5'd18;
  localparam logic [4:0] S_XLD       = 5'd19;
  localparam logic [4:0] S_DONE      = 5'd20;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        cmd.we       = 1'b1;
        cmd.addr_sel = A_CLR;
        cmd.data_sel = D_CLR;
        cmd.clr_inc  = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.addr_sel = A_PTR;
        cmd.pg_init  = 1'b1;
        if (sts.req == REQ_NEW) begin
          if (sts.pid_ok) begin
            state_nxt = S_TSCAN_RD;
          end else begin
            cmd.st_ld  = 1'b1;
            cmd.st_val = ST_NO_TABLE;
            state_nxt  = S_DONE;
          end
        end else if (sts.req == REQ_KILL) begin
          if (sts.pid_ok) begin
            state_nxt = S_KPTR;
          end else begin
            cmd.st_ld  = 1'b1;
            cmd.st_val = ST_OK;
            state_nxt  = S_DONE;
          end
        end else begin
          if (sts.pid_ok) begin
            state_nxt = S_XPTR;
          end else begin
            cmd.st_ld  = 1'b1;
            cmd.st_val = ST_NO_TABLE;
            state_nxt  = S_DONE;
          end
        end
      end
      S_TSCAN_RD: begin
        cmd.addr_sel = A_SCAN;
        if (sts.pg_end) begin
          cmd.st_ld  = 1'b1;
          cmd.st_val = ST_NO_TABLE_PAGE;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_TSCAN_CHK;
        end
      end
      S_TSCAN_CHK: begin
        cmd.addr_sel = A_SCAN;
        cmd.data_sel = D_ONE;
        cmd.pg_inc   = 1'b1;
        if (sts.rzero) begin
          cmd.we       = 1'b1;
          cmd.tp_ld_pg = 1'b1;
          state_nxt    = S_PTR_WR;
        end else begin
          state_nxt = S_TSCAN_RD;
        end
      end
      S_PTR_WR: begin
        cmd.we       = 1'b1;
        cmd.addr_sel = A_PTR;
        cmd.data_sel = D_TP;
        state_nxt    = S_DCHECK;
      end
      S_DCHECK: begin
        if (sts.vp_eq_cnt) begin
          cmd.st_ld  = 1'b1;
          cmd.st_val = ST_OK;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_DSCAN_RD;
        end
      end
      S_DSCAN_RD: begin
        cmd.addr_sel = A_SCAN;
        if (sts.pg_end) begin
          cmd.st_ld  = 1'b1;
          cmd.st_val = ST_NO_DATA_PAGE;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_DSCAN_CHK;
        end
      end
      S_DSCAN_CHK: begin
        cmd.addr_sel = A_SCAN;
        cmd.data_sel = D_ONE;
        cmd.pg_inc   = 1'b1;
        if (sts.rzero) begin
          cmd.we       = 1'b1;
          cmd.pp_ld_pg = 1'b1;
          state_nxt    = S_ENT_WR;
        end else begin
          state_nxt = S_DSCAN_RD;
        end
      end
      S_ENT_WR: begin
        cmd.we       = 1'b1;
        cmd.addr_sel = A_ENT;
        cmd.data_sel = D_PP;
        cmd.vp_inc   = 1'b1;
        state_nxt    = S_DCHECK;
      end
      S_KPTR: begin
        if (sts.rpage_ok) begin
          cmd.tp_ld_rd = 1'b1;
          cmd.vp_clr   = 1'b1;
          state_nxt    = S_KRD;
        end else begin
          cmd.st_ld  = 1'b1;
          cmd.st_val = ST_OK;
          state_nxt  = S_DONE;
        end
      end
      S_KRD: begin
        cmd.addr_sel = A_ENT;
        if (sts.vp_eq_pages) begin
          state_nxt = S_KFREE;
        end else begin
          state_nxt = S_KCHK;
        end
      end
      S_KCHK: begin
        // Any nonzero entry clears the page 0 byte it names.
        cmd.addr_sel = A_KMAP;
        cmd.data_sel = D_ZERO;
        cmd.we       = !sts.rzero;
        cmd.vp_inc   = 1'b1;
        state_nxt    = S_KRD;
      end
      S_KFREE: begin
        cmd.we       = 1'b1;
        cmd.addr_sel = A_TFREE;
        cmd.data_sel = D_ZERO;
        state_nxt    = S_KPTRCLR;
      end
      S_KPTRCLR: begin
        cmd.we       = 1'b1;
        cmd.addr_sel = A_PTR;
        cmd.data_sel = D_ZERO;
        cmd.st_ld    = 1'b1;
        cmd.st_val   = ST_OK;
        state_nxt    = S_DONE;
      end
      S_XPTR: begin
        if (sts.rpage_ok) begin
          cmd.tp_ld_rd = 1'b1;
          state_nxt    = S_XENT_RD;
        end else begin
          cmd.st_ld  = 1'b1;
          cmd.st_val = ST_NO_TABLE;
          state_nxt  = S_DONE;
        end
      end
      S_XENT_RD: begin
        cmd.addr_sel = A_XENT;
        state_nxt    = S_XENT;
      end
      S_XENT: begin
        if (sts.rpage_ok) begin
          cmd.pp_ld_rd = 1'b1;
          state_nxt    = S_XACC;
        end else begin
          cmd.st_ld  = 1'b1;
          cmd.st_val = ST_UNMAPPED;
          state_nxt  = S_DONE;
        end
      end
      S_XACC: begin
        cmd.addr_sel = A_PHYS;
        cmd.data_sel = D_WD;
        if (sts.req == REQ_STORE) begin
          cmd.we     = 1'b1;
          cmd.st_ld  = 1'b1;
          cmd.st_val = ST_OK;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_XLD;
        end
      end
      S_XLD: begin
        cmd.rd_ld  = 1'b1;
        cmd.st_ld  = 1'b1;
        cmd.st_val = ST_OK;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

endmodule

/* hw/rtl/slpt_dp.sv */
// Datapath of the page-table MMU: request registers, counters, RAM and result word.
module slpt_dp import slpt_pkg::*; #(
  parameter int NUM_PAGES = 64,
  parameter int PROC_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  in_req_type,
  input  logic [5:0]  in_proc_id,
  input  logic [6:0]  in_pages_requested,
  input  logic [13:0] in_vaddr,
  input  logic [7:0]  in_write_data,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [13:0] out_phys_addr,
  output logic [7:0]  out_read_data,
  output logic [5:0]  out_table_page,
  output logic [6:0]  out_pages_mapped
);

  localparam int DEPTH = NUM_PAGES * 256;
  localparam int PGW   = $clog2(NUM_PAGES);
  localparam int AW    = PGW + 8;

  logic [1:0]     req_r;
  logic [5:0]     pid_r;
  logic [6:0]     cnt_r;
  logic [13:0]    va_r;
  logic [7:0]     wd_r;
  logic [AW-1:0]  clr_r;
  logic [PGW:0]   pg_r;
  logic [6:0]     vp_r;
  logic [PGW-1:0] tp_r;
  logic [PGW-1:0] pp_r;
  logic [2:0]     st_r;
  logic [7:0]     rd_r;
  logic           out_valid_r;
  logic [2:0]     o_status_r;
  logic [13:0]    o_phys_r;
  logic [7:0]     o_rd_r;
  logic [5:0]     o_tp_r;
  logic [6:0]     o_mapped_r;

  logic [AW-1:0]  addr;
  logic [7:0]     wdata;
  logic [7:0]     rdata;
  logic [7:0]     ptr_off;
  logic           ok_xlat;

  assign ptr_off = {2'b01, pid_r};

  always_comb begin
    case (cmd.addr_sel)
      A_CLR:   addr = clr_r;
      A_SCAN:  addr = AW'(pg_r);
      A_PTR:   addr = AW'(ptr_off);
      A_ENT:   addr = {tp_r, 1'b0, vp_r};
      A_XENT:  addr = {tp_r, 2'b00, va_r[13:8]};
      A_KMAP:  addr = AW'(rdata);
      A_TFREE: addr = AW'(tp_r);
      A_PHYS:  addr = {pp_r, va_r[7:0]};
      default: addr = clr_r;
    endcase
  end

  always_comb begin
    case (cmd.data_sel)
      D_ZERO:  wdata = 8'd0;
      D_ONE:   wdata = 8'd1;
      D_TP:    wdata = 8'(tp_r);
      D_PP:    wdata = 8'(pp_r);
      D_WD:    wdata = wd_r;
      D_CLR:   wdata = (clr_r == '0) ? 8'd1 : 8'd0;
      default: wdata = 8'd0;
    endcase
  end

  slpt_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_inc) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req_type;
      pid_r <= in_proc_id;
      cnt_r <= in_pages_requested;
      va_r  <= in_vaddr;
      wd_r  <= in_write_data;
    end
    if (cmd.pg_init) begin
      pg_r <= (PGW+1)'(1);
    end else if (cmd.pg_inc) begin
      pg_r <= pg_r + 1'b1;
    end
    if (cmd.capture || cmd.vp_clr) begin
      vp_r <= 7'd0;
    end else if (cmd.vp_inc) begin
      vp_r <= vp_r + 7'd1;
    end
    if (cmd.capture) begin
      tp_r <= '0;
    end else if (cmd.tp_ld_pg) begin
      tp_r <= pg_r[PGW-1:0];
    end else if (cmd.tp_ld_rd) begin
      tp_r <= rdata[PGW-1:0];
    end
    if (cmd.pp_ld_pg) begin
      pp_r <= pg_r[PGW-1:0];
    end else if (cmd.pp_ld_rd) begin
      pp_r <= rdata[PGW-1:0];
    end
    if (cmd.capture) begin
      rd_r <= 8'd0;
    end else if (cmd.rd_ld) begin
      rd_r <= rdata;
    end
    if (cmd.st_ld) begin
      st_r <= cmd.st_val;
    end
  end

  assign ok_xlat = (st_r == ST_OK) && (req_r == REQ_STORE || req_r == REQ_LOAD);

  // The result word waits here so the sequencer can go on to the next request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      o_status_r <= st_r;
      o_phys_r   <= ok_xlat ? 14'({pp_r, va_r[7:0]}) : 14'd0;
      o_rd_r     <= (ok_xlat && req_r == REQ_LOAD) ? rd_r : 8'd0;
      o_tp_r     <= (req_r == REQ_NEW && (st_r == ST_OK || st_r == ST_NO_DATA_PAGE))
                    ? 6'(tp_r) : 6'd0;
      o_mapped_r <= (req_r == REQ_NEW) ? vp_r : 7'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = o_status_r;
  assign out_phys_addr    = o_phys_r;
  assign out_read_data    = o_rd_r;
  assign out_table_page   = o_tp_r;
  assign out_pages_mapped = o_mapped_r;

  assign sts.req         = req_r;
  assign sts.pid_ok      = (8'(pid_r) < 8'(PROC_COUNT));
  assign sts.rzero       = (rdata == 8'd0);
  assign sts.rpage_ok    = (rdata != 8'd0) && ({1'b0, rdata} < 9'(NUM_PAGES));
  assign sts.pg_end      = (pg_r == (PGW+1)'(NUM_PAGES));
  assign sts.vp_eq_cnt   = (vp_r == cnt_r);
  assign sts.vp_eq_pages = (vp_r == 7'(NUM_PAGES));
  assign sts.clr_last    = (clr_r == AW'(DEPTH - 1));
  assign sts.out_free    = !out_valid_r || out_ready;

endmodule
